### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files; the parser includes them.
// Each macro takes a label, the clock, the active-low reset and the expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(label, clk_sig, rst_n_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk_sig, rst_n_sig, ante, cons)

`define ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons)

`endif

`endif

### hw/rtl/lpfr_pkg.sv
package lpfr_pkg;

    // Default width of the completed-message counter.
    localparam int MSG_COUNT_BITS_DEFAULT = 16;

    // Width of the count as it appears on the result request.
    localparam int DONE_BITS = 16;

    // One result request as produced by the parser.
    typedef struct packed {
        logic [7:0]           data_byte;
        logic [7:0]           byte_index;
        logic                 last;
        logic                 checksum_ok;
        logic [DONE_BITS-1:0] messages_done;
    } lpfr_result_t;

endpackage

### hw/rtl/lpfr_in_stage.sv
module lpfr_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       item_valid,
    output logic [7:0] item_byte,
    input  logic       consume
);
    import lpfr_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;

    // The register can load whenever it is empty or its content leaves this cycle.
    assign in_ready   = !valid_reg || consume;
    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

### hw/rtl/lpfr_parser.sv
`include "assert_macros.svh"

module lpfr_parser #(
    parameter int MSG_COUNT_BITS = lpfr_pkg::MSG_COUNT_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic [7:0]           item_byte,
    input  logic                 take,
    output logic                 consume,
    output logic                 res_valid,
    output lpfr_pkg::lpfr_result_t res
);
    import lpfr_pkg::*;

    localparam int ExtBits = (MSG_COUNT_BITS > DONE_BITS) ? MSG_COUNT_BITS : DONE_BITS;

    logic                      in_message_reg;
    logic                      in_message_next;
    logic [7:0]                expected_length_reg;
    logic [7:0]                expected_length_next;
    logic [7:0]                bytes_seen_reg;
    logic [7:0]                bytes_seen_next;
    logic [7:0]                running_sum_reg;
    logic [7:0]                running_sum_next;
    logic [MSG_COUNT_BITS-1:0] count_reg;
    logic [MSG_COUNT_BITS-1:0] count_next;

    logic                      filler;
    logic [7:0]                cur_len;
    logic [7:0]                cur_seen;
    logic [7:0]                cur_sum;
    logic [7:0]                seen_inc;
    logic                      is_last;
    logic [ExtBits-1:0]        count_ext;

    // A new message starts from a clean slate, so the idle case selects zero for the seen count and the sum.
    assign filler   = !in_message_reg && (item_byte == 8'd0);
    assign cur_len  = in_message_reg ? expected_length_reg : item_byte;
    assign cur_seen = in_message_reg ? bytes_seen_reg : 8'd0;
    assign cur_sum  = in_message_reg ? running_sum_reg : 8'd0;
    assign seen_inc = cur_seen + 8'd1;
    assign is_last  = (seen_inc == cur_len);

    assign consume   = item_valid && (filler || take);
    assign res_valid = item_valid && !filler && take;

    always_comb
    begin
        in_message_next      = !is_last;
        expected_length_next = cur_len;
        bytes_seen_next      = is_last ? 8'd0 : seen_inc;
        running_sum_next     = is_last ? 8'd0 : (cur_sum + item_byte);
        count_next           = count_reg + MSG_COUNT_BITS'(is_last);
    end

    assign count_ext = ExtBits'(count_next);

    always_comb
    begin
        res.data_byte     = item_byte;
        res.byte_index    = cur_seen;
        res.last          = is_last;
        res.checksum_ok   = is_last && (cur_sum == item_byte);
        res.messages_done = count_ext[DONE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_message_reg      <= 1'b0;
            expected_length_reg <= 8'd0;
            bytes_seen_reg      <= 8'd0;
            running_sum_reg     <= 8'd0;
            count_reg           <= '0;
        end
        else if (res_valid)
        begin
            in_message_reg      <= in_message_next;
            expected_length_reg <= expected_length_next;
            bytes_seen_reg      <= bytes_seen_next;
            running_sum_reg     <= running_sum_next;
            count_reg           <= count_next;
        end
    end

    `ASSERT_IMPLY(a_idle_clean, clk, rst_n, !in_message_reg, (bytes_seen_reg == 8'd0) && (running_sum_reg == 8'd0))
    `ASSERT_IMPLY(a_msg_bounds, clk, rst_n, in_message_reg, (expected_length_reg != 8'd0) && (bytes_seen_reg < expected_length_reg))
    `ASSERT_IMPLY(a_ok_on_last, clk, rst_n, res_valid && res.checksum_ok, res.last)
    `ASSERT_NEXT(a_count_step, clk, rst_n, res_valid && res.last, count_reg == MSG_COUNT_BITS'($past(count_reg) + 1'b1))

endmodule

### hw/rtl/lpfr_out_stage.sv
module lpfr_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   res_valid,
    input  lpfr_pkg::lpfr_result_t res,
    output logic                   take,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             data_byte,
    output logic [7:0]             byte_index,
    output logic                   last,
    output logic                   checksum_ok,
    output logic [lpfr_pkg::DONE_BITS-1:0] messages_done
);
    import lpfr_pkg::*;

    logic         valid_reg;
    lpfr_result_t res_reg;

    // A new result may load when the register is empty or is being drained.
    assign take = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = valid_reg;
    assign data_byte     = res_reg.data_byte;
    assign byte_index    = res_reg.byte_index;
    assign last          = res_reg.last;
    assign checksum_ok   = res_reg.checksum_ok;
    assign messages_done = res_reg.messages_done;

endmodule

### hw/rtl/length_prefixed_frame_receiver_top.sv
// Length-prefixed frame receiver. Each input request carries one byte from a
// serial link. While no message is open, a zero byte is filler and produces no
// result; a nonzero byte opens a message and gives its total length, which
// counts the length byte itself and a closing checksum byte. Every byte of a
// message, the length byte included, comes out as one result request with its
// index in the message. The final byte is flagged with last, and checksum_ok
// tells whether it equals the 8-bit wrapping sum of all earlier bytes, so a
// message of length one always fails the check. A failed message still counts
// as complete, and messages_done carries the low 16 bits of a wrapping counter
// of completed messages, this one included. The block sustains one byte per
// clock cycle while out_ready stays high: a byte waits in the input
// register, where the parser decides on it combinationally, and then sits in
// the output register until it is taken. Filler bytes are dropped in the
// parser without waiting for the output side. in_ready follows out_ready
// combinationally when both registers are full and the held byte is not
// filler.
module length_prefixed_frame_receiver_top #(
    parameter int MSG_COUNT_BITS = lpfr_pkg::MSG_COUNT_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     rx_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     data_byte,
    output logic [7:0]                     byte_index,
    output logic                           last,
    output logic                           checksum_ok,
    output logic [lpfr_pkg::DONE_BITS-1:0] messages_done
);
    import lpfr_pkg::*;

    // Input register to parser.
    logic         item_valid;
    logic [7:0]   item_byte;
    logic         consume;

    // Parser to output register.
    logic         res_valid;
    lpfr_result_t res;
    logic         take;

    lpfr_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .consume    (consume)
    );

    // The parser holds the message state and updates it only when a
    // result actually moves into the output register.
    lpfr_parser #(
        .MSG_COUNT_BITS (MSG_COUNT_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .take       (take),
        .consume    (consume),
        .res_valid  (res_valid),
        .res        (res)
    );

    lpfr_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res           (res),
        .take          (take),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .data_byte     (data_byte),
        .byte_index    (byte_index),
        .last          (last),
        .checksum_ok   (checksum_ok),
        .messages_done (messages_done)
    );

endmodule
